// ===== rtl/smgd_pkg.sv =====
// Package of the square marker grid decoder: sizes, register codes, shared types
// and the quarter-turn function of the code word.
// No dependencies.
package smgd_pkg;

    // grid geometry
    localparam int GRID_BITS     = 5;
    localparam int CELLS         = GRID_BITS + 2;
    localparam int CODE_BITS     = GRID_BITS * GRID_BITS;
    localparam int MAX_CELL_SIZE = 64;

    // field and register widths
    localparam int PIX_W      = 8;
    localparam int IMG_W      = 9;
    localparam int CSZ_W      = 7;
    localparam int CNT_W      = 13;
    localparam int TYPE_W     = 2;
    localparam int ROT_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    // counter widths derived from the geometry
    localparam int CIC_W      = (MAX_CELL_SIZE > 1) ? $clog2(MAX_CELL_SIZE) : 1;
    localparam int CMP_W      = (CIC_W > CSZ_W) ? CIC_W : CSZ_W;
    localparam int CELL_IDX_W = $clog2(CELLS + 1);

    // reset values of the registers
    localparam logic [IMG_W-1:0]     IMAGE_SIDE_RST = IMG_W'(448);
    localparam logic [CSZ_W-1:0]     CELL_SIZE_RST  = CSZ_W'(64);
    localparam logic [CNT_W-1:0]     LIMIT_RST      = CNT_W'(2048);
    localparam logic [CODE_BITS-1:0] CODE_RST       = '0;

    // register index codes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_SIDE    = 3'd0,
        REG_CELL_SIZE     = 3'd1,
        REG_WHITE_LIMIT   = 3'd2,
        REG_BORDER_LIMIT  = 3'd3,
        REG_CODE_COIN     = 3'd4,
        REG_CODE_OBSTACLE = 3'd5,
        REG_CODE_PLAYER   = 3'd6
    } cfg_idx_t;

    // marker type codes
    localparam logic [TYPE_W-1:0] TYPE_COIN     = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_OBSTACLE = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_PLAYER   = 2'd2;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [IMG_W-1:0]     image_side;
        logic [CSZ_W-1:0]     cell_size;
        logic [CNT_W-1:0]     white_limit;
        logic [CNT_W-1:0]     border_limit;
        logic [CODE_BITS-1:0] code_coin;
        logic [CODE_BITS-1:0] code_obstacle;
        logic [CODE_BITS-1:0] code_player;
    } cfg_t;

    // finished image handed from the accumulator to the matcher
    typedef struct packed {
        logic                 valid;
        logic                 border_ok;
        logic [CODE_BITS-1:0] code;
    } fin_t;

    // one clockwise quarter turn: out(y,x) = in(GRID-1-x, y), MSB is cell (0,0)
    function automatic logic [CODE_BITS-1:0] turn_cw(input logic [CODE_BITS-1:0] code_in);
        logic [CODE_BITS-1:0] res;
        res = '0;
        for (int y = 0; y < GRID_BITS; y++) begin
            for (int x = 0; x < GRID_BITS; x++) begin
                res[CODE_BITS-1-(y*GRID_BITS+x)] =
                    code_in[CODE_BITS-1-((GRID_BITS-1-x)*GRID_BITS+y)];
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/square_marker_grid_decoder_core.sv =====
// Square marker grid decoder, top level.
// Depends on smgd_pkg, smgd_cfg_regs, smgd_grid_acc and smgd_matcher.
//
// Usage:
//   Pixels of a square, binarized, rectified marker image enter on the s_ channel
//   in raster order, one beat per pixel; any nonzero pixel counts as white.
//   The image is split into 7x7 cells; border cells are checked against the
//   border limit and the inner 5x5 cells form a 25-bit code.
//   After the last pixel of an image one result beat leaves on the m_ channel:
//   border check, match flag, marker type, quarter turns and code.
//   Throughput: one pixel per cycle while s_ready is high, also across image boundaries.
//   The result is registered in the finished-image stage and then in the
//   result register before it leaves on the m_ channel.
//   s_ready drops only while the finished-image stage and the result register
//   are both full and m_ready is low; any pixel then waits on the receiver.
//   Configuration writes go through cfg_valid/cfg_ready (always ready), indexed
//   by cfg_index; unknown indexes are dropped. Write them between images.
//   Reset (aresetn low, synchronous) restores the register defaults, clears the
//   position and count state and empties both output stages.
//   After the last pixel of each image the per-image state starts over; registers are kept.
module square_marker_grid_decoder_core
    import smgd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIX_W-1:0]      s_pixel,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_border_ok,
    output logic                  m_found,
    output logic [TYPE_W-1:0]     m_marker_type,
    output logic [ROT_W-1:0]      m_rotation,
    output logic [CODE_BITS-1:0]  m_code
);

    cfg_t cfg;
    fin_t fin;
    logic fin_ready;

    // register file
    smgd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // counting and judging
    smgd_grid_acc u_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .fin_ready (fin_ready),
        .fin       (fin)
    );

    // matching and result register
    smgd_matcher u_match (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .fin           (fin),
        .fin_ready     (fin_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_border_ok   (m_border_ok),
        .m_found       (m_found),
        .m_marker_type (m_marker_type),
        .m_rotation    (m_rotation),
        .m_code        (m_code)
    );

endmodule

// ===== rtl/smgd_cfg_regs.sv =====
// Configuration register file of the marker decoder.
// Depends on smgd_pkg.
module smgd_cfg_regs
    import smgd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_side    <= IMAGE_SIDE_RST;
            cfg_reg.cell_size     <= CELL_SIZE_RST;
            cfg_reg.white_limit   <= LIMIT_RST;
            cfg_reg.border_limit  <= LIMIT_RST;
            cfg_reg.code_coin     <= CODE_RST;
            cfg_reg.code_obstacle <= CODE_RST;
            cfg_reg.code_player   <= CODE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_IMAGE_SIDE:    cfg_reg.image_side    <= cfg_data[IMG_W-1:0];
                REG_CELL_SIZE:     cfg_reg.cell_size     <= cfg_data[CSZ_W-1:0];
                REG_WHITE_LIMIT:   cfg_reg.white_limit   <= cfg_data[CNT_W-1:0];
                REG_BORDER_LIMIT:  cfg_reg.border_limit  <= cfg_data[CNT_W-1:0];
                REG_CODE_COIN:     cfg_reg.code_coin     <= cfg_data[CODE_BITS-1:0];
                REG_CODE_OBSTACLE: cfg_reg.code_obstacle <= cfg_data[CODE_BITS-1:0];
                REG_CODE_PLAYER:   cfg_reg.code_player   <= cfg_data[CODE_BITS-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/smgd_grid_acc.sv =====
// Pixel position tracking, per-cell counting and row judging of the marker decoder.
// Depends on smgd_pkg.
module smgd_grid_acc
    import smgd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [PIX_W-1:0] s_pixel,
    input  logic             fin_ready,
    output fin_t             fin
);

    // per-image state
    logic [CNT_W-1:0]      cnt_reg [CELLS];
    logic [CNT_W-1:0]      cnt_next [CELLS];
    logic [CODE_BITS-1:0]  grid_reg, grid_next;
    logic                  border_reg, border_next;
    logic [IMG_W-1:0]      pix_col_reg, pix_col_next;
    logic [IMG_W-1:0]      pix_row_reg, pix_row_next;
    logic [CIC_W-1:0]      col_in_cell_reg, col_in_cell_next;
    logic [CIC_W-1:0]      row_in_cell_reg, row_in_cell_next;
    logic [CELL_IDX_W-1:0] cell_col_reg, cell_col_next;
    logic [CELL_IDX_W-1:0] cell_row_reg, cell_row_next;

    // finished-image stage
    logic                  fin_valid_reg;
    logic                  fin_border_reg;
    logic [CODE_BITS-1:0]  fin_code_reg;

    logic                  accept;
    logic [IMG_W-1:0]      side_m1;
    logic [CSZ_W-1:0]      cs_eff;
    logic [CMP_W-1:0]      cs_m1;
    logic                  end_row, last, row_done, judge, hit;
    logic [CNT_W-1:0]      cnt_inc [CELLS];

    assign s_ready = !fin_valid_reg || fin_ready;
    assign accept  = s_valid && s_ready;

    assign fin.valid     = fin_valid_reg;
    assign fin.border_ok = fin_border_reg;
    assign fin.code      = fin_code_reg;

    // effective sizes: zero acts as one, cell size saturates
    always_comb begin
        side_m1 = (cfg.image_side == '0) ? '0 : cfg.image_side - IMG_W'(1);
        if (cfg.cell_size == '0) begin
            cs_eff = CSZ_W'(1);
        end else if (int'(cfg.cell_size) > MAX_CELL_SIZE) begin
            cs_eff = CSZ_W'(MAX_CELL_SIZE);
        end else begin
            cs_eff = cfg.cell_size;
        end
        cs_m1 = CMP_W'(cs_eff) - CMP_W'(1);
    end

    // position decode
    assign end_row  = pix_col_reg >= side_m1;
    assign last     = end_row && (pix_row_reg >= side_m1);
    assign row_done = CMP_W'(row_in_cell_reg) >= cs_m1;
    assign judge    = end_row && row_done && (cell_row_reg < CELL_IDX_W'(CELLS));
    assign hit      = (cell_col_reg < CELL_IDX_W'(CELLS)) &&
                      (cell_row_reg < CELL_IDX_W'(CELLS)) && (s_pixel != '0);

    // count update and row judging
    always_comb begin
        grid_next   = grid_reg;
        border_next = border_reg;
        for (int c = 0; c < CELLS; c++) begin
            cnt_inc[c] = cnt_reg[c];
            if (hit && cell_col_reg == CELL_IDX_W'(c) && cnt_reg[c] != '1) begin
                cnt_inc[c] = cnt_reg[c] + CNT_W'(1);
            end
            cnt_next[c] = judge ? '0 : cnt_inc[c];
            // border cells
            if (judge && (cell_row_reg == '0 || cell_row_reg == CELL_IDX_W'(CELLS-1) ||
                          c == 0 || c == CELLS-1) && cnt_inc[c] > cfg.border_limit) begin
                border_next = 1'b0;
            end
        end
        // inner cells
        for (int r = 1; r <= GRID_BITS; r++) begin
            for (int c = 1; c <= GRID_BITS; c++) begin
                if (judge && cell_row_reg == CELL_IDX_W'(r) &&
                    cnt_inc[c] > cfg.white_limit) begin
                    grid_next[CODE_BITS-1-((r-1)*GRID_BITS+(c-1))] = 1'b1;
                end
            end
        end
    end

    // position counters
    always_comb begin
        pix_col_next     = pix_col_reg;
        pix_row_next     = pix_row_reg;
        col_in_cell_next = col_in_cell_reg;
        row_in_cell_next = row_in_cell_reg;
        cell_col_next    = cell_col_reg;
        cell_row_next    = cell_row_reg;
        if (end_row) begin
            pix_col_next     = '0;
            col_in_cell_next = '0;
            cell_col_next    = '0;
            pix_row_next     = pix_row_reg + IMG_W'(1);
            if (row_done) begin
                row_in_cell_next = '0;
                if (cell_row_reg < CELL_IDX_W'(CELLS)) begin
                    cell_row_next = cell_row_reg + CELL_IDX_W'(1);
                end
            end else begin
                row_in_cell_next = row_in_cell_reg + CIC_W'(1);
            end
        end else begin
            pix_col_next = pix_col_reg + IMG_W'(1);
            if (CMP_W'(col_in_cell_reg) >= cs_m1) begin
                col_in_cell_next = '0;
                if (cell_col_reg < CELL_IDX_W'(CELLS)) begin
                    cell_col_next = cell_col_reg + CELL_IDX_W'(1);
                end
            end else begin
                col_in_cell_next = col_in_cell_reg + CIC_W'(1);
            end
        end
    end

    // state registers; the last pixel of an image returns them to reset
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && last)) begin
            for (int c = 0; c < CELLS; c++) begin
                cnt_reg[c] <= '0;
            end
            grid_reg        <= '0;
            border_reg      <= 1'b1;
            pix_col_reg     <= '0;
            pix_row_reg     <= '0;
            col_in_cell_reg <= '0;
            row_in_cell_reg <= '0;
            cell_col_reg    <= '0;
            cell_row_reg    <= '0;
        end else if (accept) begin
            for (int c = 0; c < CELLS; c++) begin
                cnt_reg[c] <= cnt_next[c];
            end
            grid_reg        <= grid_next;
            border_reg      <= border_next;
            pix_col_reg     <= pix_col_next;
            pix_row_reg     <= pix_row_next;
            col_in_cell_reg <= col_in_cell_next;
            row_in_cell_reg <= row_in_cell_next;
            cell_col_reg    <= cell_col_next;
            cell_row_reg    <= cell_row_next;
        end
    end

    // finished-image stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (accept && last) begin
            fin_valid_reg <= 1'b1;
        end else if (fin_ready) begin
            fin_valid_reg <= 1'b0;
        end
    end

    // finished-image payload
    always_ff @(posedge aclk) begin
        if (accept && last) begin
            fin_border_reg <= border_next;
            fin_code_reg   <= grid_next;
        end
    end

endmodule

// ===== rtl/smgd_matcher.sv =====
// Rotation matcher and result register of the marker decoder.
// Depends on smgd_pkg.
module smgd_matcher
    import smgd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  fin_t                 fin,
    output logic                 fin_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_border_ok,
    output logic                 m_found,
    output logic [TYPE_W-1:0]    m_marker_type,
    output logic [ROT_W-1:0]     m_rotation,
    output logic [CODE_BITS-1:0] m_code
);

    logic                 m_valid_reg;
    logic                 border_ok_reg;
    logic                 found_reg, found_next;
    logic [TYPE_W-1:0]    type_reg, type_next;
    logic [ROT_W-1:0]     rot_reg, rot_next;
    logic [CODE_BITS-1:0] code_reg, code_next;
    logic [CODE_BITS-1:0] turned [4];

    assign fin_ready     = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_border_ok   = border_ok_reg;
    assign m_found       = found_reg;
    assign m_marker_type = type_reg;
    assign m_rotation    = rot_reg;
    assign m_code        = code_reg;

    // all four rotations are pure wiring
    assign turned[0] = fin.code;
    assign turned[1] = turn_cw(turned[0]);
    assign turned[2] = turn_cw(turned[1]);
    assign turned[3] = turn_cw(turned[2]);

    // first match wins: rotation order, then coin, obstacle, player
    always_comb begin
        found_next = 1'b0;
        type_next  = TYPE_COIN;
        rot_next   = '0;
        code_next  = fin.code;
        if (fin.border_ok) begin
            for (int r = 0; r < 4; r++) begin
                if (!found_next) begin
                    if (turned[r] == cfg.code_coin) begin
                        found_next = 1'b1;
                        type_next  = TYPE_COIN;
                    end else if (turned[r] == cfg.code_obstacle) begin
                        found_next = 1'b1;
                        type_next  = TYPE_OBSTACLE;
                    end else if (turned[r] == cfg.code_player) begin
                        found_next = 1'b1;
                        type_next  = TYPE_PLAYER;
                    end
                    if (found_next) begin
                        rot_next  = ROT_W'(r);
                        code_next = turned[r];
                    end
                end
            end
        end
    end

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin.valid && fin_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (fin.valid && fin_ready) begin
            border_ok_reg <= fin.border_ok;
            found_reg     <= found_next;
            type_reg      <= type_next;
            rot_reg       <= rot_next;
            code_reg      <= code_next;
        end
    end

endmodule

// ===== rtl/smgd_checker.sv =====
// Port-level checks of the square marker grid decoder, bound to the top level.
// Depends on smgd_pkg and square_marker_grid_decoder_core.
module smgd_checker
    import smgd_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic                 m_border_ok,
    input logic                 m_found,
    input logic [TYPE_W-1:0]    m_marker_type,
    input logic [ROT_W-1:0]     m_rotation,
    input logic [CODE_BITS-1:0] m_code
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // stalled result beat holds its code, match flag, type and rotation
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code) && $stable(m_found) &&
                                $stable(m_marker_type) && $stable(m_rotation))
        else $error("stalled result changed");

    // a match needs a clean border
    a_found_border: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_border_ok)
        else $error("match reported with failed border");

    // no match reports type and rotation zero
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_marker_type == TYPE_COIN && m_rotation == '0)
        else $error("type or rotation set without match");

    // type code three never appears
    a_type_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_marker_type == TYPE_COIN || m_marker_type == TYPE_OBSTACLE ||
                    m_marker_type == TYPE_PLAYER)
        else $error("undefined marker type");

endmodule

bind square_marker_grid_decoder_core smgd_checker u_smgd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_border_ok   (m_border_ok),
    .m_found       (m_found),
    .m_marker_type (m_marker_type),
    .m_rotation    (m_rotation),
    .m_code        (m_code)
);
